FILE: design/smr_pkg.sv
package smr_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int DIM_W       = 5;
  localparam int DIM_RESET   = 16;
  localparam int VALUE_W     = 32;
  localparam int ROW_W       = 4;
  localparam int COL_W       = 4;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROT_CW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROT_CCW = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

  localparam int IN_DATA_W  = ROW_W + COL_W + VALUE_W;
  localparam int OUT_DATA_W = VALUE_W;

endpackage

FILE: design/smr_ram.sv
module smr_ram #(
  parameter int AW = 8,
  parameter int DW = smr_pkg::VALUE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/square_matrix_rotate_90_unit.sv
// Writes may follow every cycle unless a rotation or stalled read holds the input.
// Reads likewise; results pass the RAM read register, then the output register.
// A rotation holds the input during a copy sweep of the whole store into the
// second memory bank at one entry per cycle through its write port.
// Reset (rst_n low, synchronous) clears control state and sets dimension to 16;
// matrix memories are not cleared and read as undefined until written.
module square_matrix_rotate_90_unit #(
  parameter int MAX_DIM = smr_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: dimension
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smr_pkg::DIM_W-1:0]     cfg_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [smr_pkg::IN_DATA_W-1:0] in_tdata,  // row[3:0], col[7:4], value[39:8]
  input  logic [smr_pkg::KIND_W-1:0]    in_tuser,  // kind[1:0]
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [smr_pkg::OUT_DATA_W-1:0] out_tdata, // read_data[31:0]
  output logic                          out_tuser   // beyond_size[0]
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int AW     = 2 * IDX_W;
  localparam int NW_MIN = $clog2(MAX_DIM + 1);
  localparam int NW     = (NW_MIN > smr_pkg::DIM_W) ? NW_MIN : smr_pkg::DIM_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DIM - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [smr_pkg::DIM_W-1:0] dim_r;
  logic [1:0]       state_r, state_nxt;
  logic             bank_r, bank_nxt;
  logic             rot_cw_r, rot_cw_nxt;
  logic [IDX_W-1:0] sr_r, sr_nxt, sc_r, sc_nxt;
  logic             sw_wr_r, sw_wr_nxt;
  logic [AW-1:0]    sw_waddr_r, sw_waddr_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_beyond_r, rd_beyond_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [smr_pkg::VALUE_W-1:0] out_data_r, out_data_nxt;
  logic             out_beyond_r, out_beyond_nxt;

  logic [smr_pkg::ROW_W-1:0]   in_row;
  logic [smr_pkg::COL_W-1:0]   in_col;
  logic [smr_pkg::VALUE_W-1:0] in_value;
  logic [NW-1:0]    n_act, dim_ext, row_ext, col_ext, sr_ext, sc_ext;
  logic [NW-1:0]    src_r_ext, src_c_ext;
  logic             item_inside, in_acc, out_free;
  logic [AW-1:0]    item_addr, src_addr;
  logic             sweep_in_win;

  // bank-side signals
  logic             cur_we, cur_re, oth_we;
  logic [AW-1:0]    cur_waddr, cur_raddr;
  logic [smr_pkg::VALUE_W-1:0] cur_rdata, rdata0, rdata1;
  logic             we0, we1, re0, re1;
  logic [AW-1:0]    waddr0, waddr1, raddr0, raddr1;
  logic [smr_pkg::VALUE_W-1:0] wdata0, wdata1;

  assign in_row   = in_tdata[smr_pkg::ROW_W-1:0];
  assign in_col   = in_tdata[smr_pkg::ROW_W+smr_pkg::COL_W-1:smr_pkg::ROW_W];
  assign in_value = in_tdata[smr_pkg::IN_DATA_W-1:smr_pkg::ROW_W+smr_pkg::COL_W];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= smr_pkg::DIM_W'(smr_pkg::DIM_RESET);
    end else if (cfg_valid) begin
      dim_r <= cfg_data;
    end
  end

  // active size saturates at MAX_DIM
  assign dim_ext = NW'(dim_r);
  assign n_act   = (dim_ext > NW'(MAX_DIM)) ? NW'(MAX_DIM) : dim_ext;

  assign row_ext     = NW'(in_row);
  assign col_ext     = NW'(in_col);
  assign item_inside = (row_ext < n_act) && (col_ext < n_act);
  assign item_addr   = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && (!rd_pend_r || out_free);
  assign in_acc    = in_tvalid && in_tready;

  // sweep source: cw takes (n-1-c, r), ccw takes (c, n-1-r); outside window copies itself
  assign sr_ext       = NW'(sr_r);
  assign sc_ext       = NW'(sc_r);
  assign sweep_in_win = (sr_ext < n_act) && (sc_ext < n_act);
  always_comb begin
    if (!sweep_in_win) begin
      src_r_ext = sr_ext;
      src_c_ext = sc_ext;
    end else if (rot_cw_r) begin
      src_r_ext = n_act - NW'(1) - sc_ext;
      src_c_ext = sr_ext;
    end else begin
      src_r_ext = sc_ext;
      src_c_ext = n_act - NW'(1) - sr_ext;
    end
  end
  assign src_addr = {src_r_ext[IDX_W-1:0], src_c_ext[IDX_W-1:0]};

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    rot_cw_nxt     = rot_cw_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    sw_wr_nxt      = 1'b0;
    sw_waddr_nxt   = sw_waddr_r;
    rd_pend_nxt    = rd_pend_r;
    rd_beyond_nxt  = rd_beyond_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_beyond_nxt = out_beyond_r;
    cur_we         = 1'b0;
    cur_waddr      = item_addr;
    cur_re         = 1'b0;
    cur_raddr      = item_addr;

    // result register
    if (rd_pend_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = rd_beyond_r ? '0 : cur_rdata;
      out_beyond_nxt = rd_beyond_r;
      rd_pend_nxt    = 1'b0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            smr_pkg::KIND_WRITE: begin
              cur_we = item_inside;
            end
            smr_pkg::KIND_READ: begin
              cur_re        = item_inside;
              rd_pend_nxt   = 1'b1;
              rd_beyond_nxt = !item_inside;
            end
            default: begin
              rot_cw_nxt = (in_tuser == smr_pkg::KIND_ROT_CW);
              sr_nxt     = '0;
              sc_nxt     = '0;
              state_nxt  = ST_SWEEP;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        cur_re       = 1'b1;
        cur_raddr    = src_addr;
        sw_wr_nxt    = 1'b1;
        sw_waddr_nxt = {sr_r, sc_r};
        if (sc_r == LAST_IDX) begin
          sc_nxt = '0;
          if (sr_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            sr_nxt = sr_r + IDX_W'(1);
          end
        end else begin
          sc_nxt = sc_r + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        // last copy lands this cycle; new bank is current from the next
        bank_nxt  = !bank_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign oth_we = sw_wr_r;

  assign cur_rdata = bank_r ? rdata1 : rdata0;
  assign we0    = bank_r ? oth_we : cur_we;
  assign we1    = bank_r ? cur_we : oth_we;
  assign waddr0 = bank_r ? sw_waddr_r : cur_waddr;
  assign waddr1 = bank_r ? cur_waddr : sw_waddr_r;
  assign wdata0 = bank_r ? cur_rdata : in_value;
  assign wdata1 = bank_r ? in_value : cur_rdata;
  assign re0    = !bank_r && cur_re;
  assign re1    = bank_r && cur_re;
  assign raddr0 = cur_raddr;
  assign raddr1 = cur_raddr;

  smr_ram #(.AW(AW), .DW(smr_pkg::VALUE_W)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .re    (re0),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  smr_ram #(.AW(AW), .DW(smr_pkg::VALUE_W)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .re    (re1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      sw_wr_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      sw_wr_r     <= sw_wr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_cw_r     <= rot_cw_nxt;
    sr_r         <= sr_nxt;
    sc_r         <= sc_nxt;
    sw_waddr_r   <= sw_waddr_nxt;
    rd_beyond_r  <= rd_beyond_nxt;
    out_data_r   <= out_data_nxt;
    out_beyond_r <= out_beyond_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_beyond_r;

`ifndef SYNTHESIS
  a_rot_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == smr_pkg::KIND_ROT_CW || in_tuser == smr_pkg::KIND_ROT_CCW))
    |=> (state_r == ST_SWEEP))
    else $error("rotation did not start a sweep");

  a_pending_read_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r && !out_free) |=> rd_pend_r)
    else $error("pending read dropped while output busy");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> (bank_r != $past(bank_r)))
    else $error("bank did not flip at end of sweep");

  a_copy_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sw_wr_r |-> (state_r == ST_SWEEP || state_r == ST_FLUSH))
    else $error("sweep copy outside of sweep");
`endif

endmodule
